// File: sv/tcw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg - shared types and codes of the text console writer
// Input mode codes, queue entry layout and configuration register indexes.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // input mode codes
    localparam logic [2:0] MODE_STYLED = 3'd0;
    localparam logic [2:0] MODE_RAW    = 3'd1;
    localparam logic [2:0] MODE_SET    = 3'd2;
    localparam logic [2:0] MODE_CLEAR  = 3'd3;
    localparam logic [2:0] MODE_READ   = 3'd4;

    // operations handed from the front to the back
    typedef logic [2:0] t_op;
    localparam t_op OP_PUT   = 3'd0;
    localparam t_op OP_SET   = 3'd1;
    localparam t_op OP_CLEAR = 3'd2;
    localparam t_op OP_READ  = 3'd3;
    localparam t_op OP_NOP   = 3'd4;

    // configuration register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_TEXT_STYLE   = 2'd0;
    localparam t_cfg_idx CFG_CURSOR_EN    = 2'd1;
    localparam t_cfg_idx CFG_CURSOR_START = 2'd2;
    localparam t_cfg_idx CFG_CURSOR_END   = 2'd3;

    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam int         POS_W        = 11;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef struct packed {
        t_op              op;
        logic [15:0]      cell_data;
        logic             newline;
        logic             moved;
        logic             in_range;
        logic [POS_W-1:0] pos;
    } t_entry;

endpackage
`default_nettype wire

// File: sv/tcw_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_front - input classifier
// Accepts input beats, decodes the mode and builds one queue entry per beat.
// ----------------------------------------------------------------------------
module tcw_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [2:0]               i_mode,
    input  wire logic [7:0]               i_char_code,
    input  wire logic [15:0]              i_cell_value,
    input  wire logic [tcw_pkg::POS_W-1:0] i_cell_position,
    input  wire logic [7:0]               i_cell_style,
    input  wire logic [7:0]               i_text_style,
    input  wire logic                     i_cursor_enabled,
    input  wire logic                     i_queue_full,
    input  wire logic                     i_init,
    output logic                          o_push,
    output tcw_pkg::t_entry               o_entry
);

    localparam int CELL_COUNT = COLUMNS * ROWS;

    logic w_in_range;

    assign w_in_range = (32'(i_cell_position) < CELL_COUNT);

    // hold off input while the queue is full or the reset clearing pass runs
    assign o_in_stall = i_queue_full | i_init;
    assign o_push     = i_in_valid & ~o_in_stall;

    always_comb begin
        o_entry          = '0;
        o_entry.pos      = i_cell_position;
        o_entry.in_range = w_in_range;
        unique case (i_mode)
            tcw_pkg::MODE_STYLED: begin
                o_entry.op        = tcw_pkg::OP_PUT;
                o_entry.cell_data = {i_text_style, i_char_code};
                o_entry.moved     = i_cursor_enabled;
            end
            tcw_pkg::MODE_RAW: begin
                o_entry.op        = tcw_pkg::OP_PUT;
                o_entry.cell_data = i_cell_value;
                o_entry.moved     = i_cursor_enabled;
            end
            tcw_pkg::MODE_SET: begin
                o_entry.op        = tcw_pkg::OP_SET;
                o_entry.cell_data = {i_cell_style, i_char_code};
            end
            tcw_pkg::MODE_CLEAR: begin
                o_entry.op    = tcw_pkg::OP_CLEAR;
                o_entry.moved = 1'b1;
            end
            tcw_pkg::MODE_READ: begin
                o_entry.op = tcw_pkg::OP_READ;
            end
            default: begin
                o_entry.op = tcw_pkg::OP_NOP;
            end
        endcase
        o_entry.newline = (o_entry.cell_data[7:0] == tcw_pkg::NEWLINE_CODE);
    end

endmodule
`default_nettype wire

// File: sv/tcw_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_queue - short entry queue
// Two-entry FIFO that decouples the classifier from the cell writer.
// ----------------------------------------------------------------------------
module tcw_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire tcw_pkg::t_entry i_data,
    input  wire logic            i_pop,
    output logic                 o_full,
    output logic                 o_valid,
    output tcw_pkg::t_entry      o_data
);

    tcw_pkg::t_entry                r_mem [tcw_pkg::QDEPTH];
    logic [tcw_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [tcw_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [tcw_pkg::QPTR_W:0]       r_count;

    assign o_full  = (r_count == (tcw_pkg::QPTR_W+1)'(tcw_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// File: sv/tcw_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_back - cell writer
// Owns the cell store and write position; executes queued operations,
// runs scroll, clear and reset sweeps, and holds the result register.
// ----------------------------------------------------------------------------
module tcw_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_head_valid,
    input  wire tcw_pkg::t_entry           i_head,
    output logic                           o_pop,
    input  wire logic [15:0]               i_blank,
    input  wire logic                      i_out_stall,
    output logic                           o_out_valid,
    output logic [tcw_pkg::POS_W-1:0]      o_write_position,
    output logic                           o_cursor_moved,
    output logic [15:0]                    o_read_data,
    output logic                           o_init
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int CW         = $clog2(COLUMNS);
    localparam int PW         = (AW > tcw_pkg::POS_W) ? AW : tcw_pkg::POS_W;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_READ   = 2'd1;
    localparam logic [1:0] S_SCROLL = 2'd2;
    localparam logic [1:0] S_FILL   = 2'd3;

    logic [15:0]   r_mem [CELL_COUNT];
    logic [15:0]   r_rd_data;

    logic [1:0]    r_state;
    logic          r_init;
    logic [AW-1:0] r_pos;
    logic [CW-1:0] r_col;
    logic [AW-1:0] r_idx;
    logic [15:0]   r_blank;
    logic          r_cp_valid;
    logic [AW-1:0] r_cp_addr;

    logic          r_out_valid;
    logic [AW-1:0] r_out_pos;
    logic          r_out_moved;
    logic [15:0]   r_out_data;

    logic          w_out_free;
    logic [PW-1:0] w_head_pos_ext;
    logic [AW-1:0] w_head_addr;
    logic [AW:0]   w_pos_next;
    logic          w_wrap;
    logic [CW-1:0] w_col_next;
    logic [PW-1:0] w_out_pos_ext;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [15:0]   w_wdata;
    logic [AW-1:0] w_raddr;

    assign w_out_free     = ~r_out_valid | ~i_out_stall;
    assign o_pop          = i_head_valid & (r_state == S_IDLE) & ~r_init & w_out_free;
    assign o_init         = r_init;

    assign w_head_pos_ext = PW'(i_head.pos);
    assign w_head_addr    = w_head_pos_ext[AW-1:0];

    // newline jumps to column 0 of the next row, anything else steps by one
    assign w_pos_next = i_head.newline
                      ? ((AW+1)'(r_pos) - (AW+1)'(r_col) + (AW+1)'(COLUMNS))
                      : ((AW+1)'(r_pos) + 1'b1);
    assign w_wrap     = (w_pos_next == (AW+1)'(CELL_COUNT));
    assign w_col_next = (i_head.newline || r_col == CW'(COLUMNS - 1)) ? '0 : r_col + 1'b1;

    // single write port: pending copy first, then fill sweep, then dispatch
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = r_blank;
        priority if (r_cp_valid) begin
            w_we    = 1'b1;
            w_waddr = r_cp_addr;
            w_wdata = r_rd_data;
        end else if (r_state == S_FILL) begin
            w_we = 1'b1;
        end else if (o_pop && i_head.op == tcw_pkg::OP_PUT && !i_head.newline) begin
            w_we    = 1'b1;
            w_waddr = r_pos;
            w_wdata = i_head.cell_data;
        end else if (o_pop && i_head.op == tcw_pkg::OP_SET && i_head.in_range) begin
            w_we    = 1'b1;
            w_waddr = w_head_addr;
            w_wdata = i_head.cell_data;
        end
    end

    assign w_raddr = (r_state == S_SCROLL) ? (r_idx + AW'(COLUMNS)) : w_head_addr;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_init      <= 1'b1;
            r_pos       <= '0;
            r_col       <= '0;
            r_idx       <= '0;
            r_blank     <= '0;
            r_cp_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cp_valid <= (r_state == S_SCROLL);
            r_cp_addr  <= r_idx;

            if (!r_out_valid || !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_out_valid <= 1'b1;
                        r_out_pos   <= r_pos;
                        r_out_moved <= i_head.moved;
                        r_out_data  <= '0;
                        unique case (i_head.op)
                            tcw_pkg::OP_PUT: begin
                                r_col <= w_col_next;
                                if (w_wrap) begin
                                    r_pos     <= AW'(CELL_COUNT - COLUMNS);
                                    r_out_pos <= AW'(CELL_COUNT - COLUMNS);
                                    r_blank   <= i_blank;
                                    r_idx     <= '0;
                                    r_state   <= S_SCROLL;
                                end else begin
                                    r_pos     <= w_pos_next[AW-1:0];
                                    r_out_pos <= w_pos_next[AW-1:0];
                                end
                            end
                            tcw_pkg::OP_CLEAR: begin
                                r_pos     <= '0;
                                r_col     <= '0;
                                r_out_pos <= '0;
                                r_blank   <= i_blank;
                                r_idx     <= '0;
                                r_state   <= S_FILL;
                            end
                            tcw_pkg::OP_READ: begin
                                if (i_head.in_range) begin
                                    r_out_valid <= 1'b0;
                                    r_state     <= S_READ;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_out_valid <= 1'b1;
                    r_out_data  <= r_rd_data;
                    r_state     <= S_IDLE;
                end
                S_SCROLL: begin
                    if (r_idx == AW'(CELL_COUNT - COLUMNS - 1)) begin
                        r_idx   <= AW'(CELL_COUNT - COLUMNS);
                        r_state <= S_FILL;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_FILL: begin
                    if (!r_cp_valid) begin
                        if (r_idx == AW'(CELL_COUNT - 1)) begin
                            r_init  <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign w_out_pos_ext    = PW'(r_out_pos);
    assign o_out_valid      = r_out_valid;
    assign o_write_position = w_out_pos_ext[tcw_pkg::POS_W-1:0];
    assign o_cursor_moved   = r_out_moved;
    assign o_read_data      = r_out_data;

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pos) < CELL_COUNT)
        else $error("write position beyond the grid");

    a_read_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !r_out_valid)
        else $error("read result would overwrite a pending result");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE && !r_init && w_out_free))
        else $error("dispatch while busy");

    a_copy_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cp_valid |-> (r_state == S_SCROLL || r_state == S_FILL))
        else $error("scroll copy pending outside a sweep");

endmodule
`default_nettype wire

// File: sv/text_console_writer.sv
`default_nettype none
// A beat is queued, then popped by the writer, which registers its result; a read waits
// in S_READ for the store's read register. One character, raw, set or no-op beat per
// cycle unless a sweep runs or the output stalls. A scroll moves each row up by one and
// blanks the last, a clear blanks every cell, both bounded by the store's single write
// port; queued beats wait behind them. Reset: synchronous, active low; then a clearing
// pass zeroes the store with input stalled. Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
// text_console_writer - text-mode screen writer
// Classifies incoming beats, queues them, and writes a grid of 16-bit cells
// with a walking write position, newline handling and eager scrolling.
// ----------------------------------------------------------------------------
module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // input channel
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [2:0]                i_mode,
    input  wire logic [7:0]                i_char_code,
    input  wire logic [15:0]               i_cell_value,
    input  wire logic [tcw_pkg::POS_W-1:0] i_cell_position,
    input  wire logic [7:0]                i_cell_style,
    input  wire logic                      i_last_of_text,
    // output channel
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic [tcw_pkg::POS_W-1:0]      o_write_position,
    output logic                           o_cursor_moved,
    output logic [15:0]                    o_read_data,
    // configuration write channel
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire tcw_pkg::t_cfg_idx         i_cfg_index,
    input  wire logic [7:0]                i_cfg_data
);

    logic [7:0]      r_text_style;
    logic            r_cursor_enabled;
    logic [4:0]      r_cursor_start_line;
    logic [4:0]      r_cursor_end_line;

    logic            w_push;
    logic            w_pop;
    logic            w_full;
    logic            w_head_valid;
    logic            w_init;
    tcw_pkg::t_entry w_entry;
    tcw_pkg::t_entry w_head;
    logic            w_last_unused;

    // the end-of-string mark changes neither cells nor results
    assign w_last_unused = i_last_of_text;

    // registers are plain flops; accept a write every cycle
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_style        <= 8'd7;
            r_cursor_enabled    <= 1'b1;
            r_cursor_start_line <= 5'd0;
            r_cursor_end_line   <= 5'd15;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                tcw_pkg::CFG_TEXT_STYLE:   r_text_style        <= i_cfg_data;
                tcw_pkg::CFG_CURSOR_EN:    r_cursor_enabled    <= i_cfg_data[0];
                tcw_pkg::CFG_CURSOR_START: r_cursor_start_line <= i_cfg_data[4:0];
                tcw_pkg::CFG_CURSOR_END:   r_cursor_end_line   <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    // front: decode each beat into an operation entry
    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_mode           (i_mode),
        .i_char_code      (i_char_code),
        .i_cell_value     (i_cell_value),
        .i_cell_position  (i_cell_position),
        .i_cell_style     (i_cell_style),
        .i_text_style     (r_text_style),
        .i_cursor_enabled (r_cursor_enabled),
        .i_queue_full     (w_full),
        .i_init           (w_init),
        .o_push           (w_push),
        .o_entry          (w_entry)
    );

    // queue: lets the front take beats, up to two entries, while the back is busy
    tcw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_entry),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_head_valid),
        .o_data  (w_head)
    );

    // back: cell store, write position, sweeps and the result register
    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head_valid     (w_head_valid),
        .i_head           (w_head),
        .o_pop            (w_pop),
        .i_blank          ({r_text_style, 8'h00}),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_write_position (o_write_position),
        .o_cursor_moved   (o_cursor_moved),
        .o_read_data      (o_read_data),
        .o_init           (w_init)
    );

endmodule
`default_nettype wire
